[hdl/btpc_pkg.sv]
package btpc_pkg;

  // Calibration word set, as written through the configuration port
  typedef struct packed {
    logic [15:0] sens_base;
    logic [15:0] offset_base;
    logic [15:0] sens_temp_coeff;
    logic [15:0] offset_temp_coeff;
    logic [15:0] ref_temperature;
    logic [15:0] temp_sensitivity;
  } cal_t;

  // Register indexes of the configuration port
  typedef enum logic [2:0] {
    REG_SENS_BASE         = 3'd0,
    REG_OFFSET_BASE       = 3'd1,
    REG_SENS_TEMP_COEFF   = 3'd2,
    REG_OFFSET_TEMP_COEFF = 3'd3,
    REG_REF_TEMPERATURE   = 3'd4,
    REG_TEMP_SENSITIVITY  = 3'd5
  } cfg_reg_e;

  localparam int CFG_INDEX_W = 3;

  // 20.00 C, the point below which second-order terms apply
  localparam logic signed [18:0] TEMP_REF = 19'sd2000;
  // Distance from 20.00 C down to -15.00 C
  localparam logic signed [18:0] COLD_SPAN = 19'sd3500;

endpackage

[hdl/btpc_cal_regs.sv]
module btpc_cal_regs
  import btpc_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_valid,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [15:0]            cfg_data,
  output cal_t                   cal
);

  cal_t cal_next;

  // Decode the write transaction; unknown indexes leave the words alone
  always_comb begin
    cal_next = cal;
    if (cfg_valid) begin
      case (cfg_index)
        REG_SENS_BASE:         cal_next.sens_base         = cfg_data;
        REG_OFFSET_BASE:       cal_next.offset_base       = cfg_data;
        REG_SENS_TEMP_COEFF:   cal_next.sens_temp_coeff   = cfg_data;
        REG_OFFSET_TEMP_COEFF: cal_next.offset_temp_coeff = cfg_data;
        REG_REF_TEMPERATURE:   cal_next.ref_temperature   = cfg_data;
        REG_TEMP_SENSITIVITY:  cal_next.temp_sensitivity  = cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cal <= '0;
    end else begin
      cal <= cal_next;
    end
  end

endmodule

[hdl/baro_temp_pressure_compensation.sv]
// Second-order compensated barometer: one raw pressure/temperature pair in,
// temperature (0.01 C) and pressure (0.01 mbar, saturated to 32 bits) out.
// A pair is taken on every cycle that start is high; busy never rises. Each
// result passes through the seven register stages of the datapath and comes
// out with done high for exactly one cycle, and the results arrive in input
// order. The receiver cannot stall the block, so it must take every done
// cycle. The deepest stages hold the multipliers, the widest being the
// 25 x 25 bit square of dT.
// Calibration words are written through the cfg port (always ready) and
// should only change while no pair is in flight.
module baro_temp_pressure_compensation
  import btpc_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  logic [23:0]              raw_press,
  input  logic [23:0]              raw_temp,
  output logic                     done,
  output logic signed [18:0]       temp_centideg,
  output logic signed [31:0]       press_centimbar,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_INDEX_W-1:0]   cfg_index,
  input  logic [15:0]              cfg_data
);

  cal_t cal;

  // Valid bits, one per stage
  logic v1, v2, v3, v4, v5, v6;

  // Stage 1: temperature difference
  logic signed [24:0] dt1;
  logic [23:0]        d1_1;
  // Stage 2: products with dT
  logic signed [41:0] mt2, moff2, msens2;
  logic signed [49:0] mdd2;
  logic [23:0]        d1_2;
  // Stage 3: first-order temperature and linear offset / sensitivity
  logic signed [18:0] hi3, lo3, temp3;
  logic               cold3, frost3;
  logic [17:0]        t2_3;
  logic signed [41:0] offb3, sensb3;
  logic [23:0]        d1_3;
  // Stage 4: squares
  logic signed [37:0] hisq4, losq4;
  logic               cold4, frost4;
  logic signed [18:0] temp4;
  logic [17:0]        t2_4;
  logic signed [41:0] offb4, sensb4;
  logic [23:0]        d1_4;
  // Stage 5: corrected offset and sensitivity
  logic signed [41:0] off5, sens5;
  logic signed [18:0] tout5;
  logic [23:0]        d1_5;
  // Stage 6: partial products of raw pressure and sensitivity
  logic signed [45:0] pa6;
  logic [44:0]        pb6;
  logic signed [41:0] off6;
  logic signed [18:0] tout6;

  // Combinational terms between stages
  logic signed [18:0] hi_c;
  logic signed [41:0] offlin_c, senslin_c;
  logic signed [41:0] sq5_c, lsq_c, lsqh_c, off2_c, sens2_c;
  logic signed [19:0] tout_c;
  logic signed [47:0] x_c;
  logic signed [32:0] p_c;
  logic signed [31:0] psat_c;

  btpc_cal_regs u_cal (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cal       (cal)
  );

  assign cfg_ready = 1'b1;
  // Fully pipelined, no back pressure: a new pair may enter every cycle
  assign busy      = 1'b0;

  // Stage 3 terms: floor shifts of the dT products
  always_comb begin
    hi_c      = mt2[41:23];
    offlin_c  = $signed({10'd0, cal.offset_base, 16'd0})
              + $signed({{7{moff2[41]}}, moff2[41:7]});
    senslin_c = $signed({11'd0, cal.sens_base, 15'd0})
              + $signed({{8{msens2[41]}}, msens2[41:8]});
  end

  // Stage 5 terms: second-order offset and sensitivity, shift-add only, and the corrected temperature
  always_comb begin
    sq5_c   = $signed({{4{hisq4[37]}}, hisq4}) * 42'sd1;
    sq5_c   = (sq5_c <<< 2) + sq5_c;
    lsq_c   = frost4 ? $signed({{4{losq4[37]}}, losq4}) : 42'sd0;
    lsqh_c  = lsq_c >>> 1;
    off2_c  = '0;
    sens2_c = '0;
    if (cold4) begin
      off2_c  = (sq5_c >>> 1) + ((lsq_c <<< 3) - lsq_c);
      sens2_c = (sq5_c >>> 2) + ((lsqh_c <<< 3) + (lsqh_c <<< 1) + lsqh_c);
    end
    tout_c = $signed({temp4[18], temp4}) - $signed({2'b00, t2_4});
  end

  // Stage 7 terms: recombine partial products, final shift, saturation
  always_comb begin
    x_c = $signed({{2{pa6[45]}}, pa6}) + $signed({24'd0, pb6[44:21]})
        - $signed({{6{off6[41]}}, off6});
    p_c = x_c[47:15];
    if (p_c[32] != p_c[31]) begin
      psat_c = p_c[32] ? {1'b1, 31'd0} : {1'b0, {31{1'b1}}};
    end else begin
      psat_c = p_c[31:0];
    end
  end

  // Valid chain
  always_ff @(posedge clk) begin
    if (rst) begin
      v1   <= 1'b0;
      v2   <= 1'b0;
      v3   <= 1'b0;
      v4   <= 1'b0;
      v5   <= 1'b0;
      v6   <= 1'b0;
      done <= 1'b0;
    end else begin
      v1   <= start & ~busy;
      v2   <= v1;
      v3   <= v2;
      v4   <= v3;
      v5   <= v4;
      v6   <= v5;
      done <= v6;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    // stage 1
    dt1    <= $signed({1'b0, raw_temp}) - $signed({1'b0, cal.ref_temperature, 8'd0});
    d1_1   <= raw_press;
    // stage 2
    mt2    <= dt1 * $signed({1'b0, cal.temp_sensitivity});
    moff2  <= dt1 * $signed({1'b0, cal.offset_temp_coeff});
    msens2 <= dt1 * $signed({1'b0, cal.sens_temp_coeff});
    mdd2   <= dt1 * dt1;
    d1_2   <= d1_1;
    // stage 3
    hi3    <= hi_c;
    lo3    <= hi_c + COLD_SPAN;
    temp3  <= hi_c + TEMP_REF;
    cold3  <= hi_c[18];
    frost3 <= hi_c[18] & (hi_c < -COLD_SPAN);
    t2_3   <= hi_c[18] ? mdd2[48:31] : 18'd0;
    offb3  <= offlin_c;
    sensb3 <= senslin_c;
    d1_3   <= d1_2;
    // stage 4
    hisq4  <= hi3 * hi3;
    losq4  <= lo3 * lo3;
    cold4  <= cold3;
    frost4 <= frost3;
    temp4  <= temp3;
    t2_4   <= t2_3;
    offb4  <= offb3;
    sensb4 <= sensb3;
    d1_4   <= d1_3;
    // stage 5
    off5   <= offb4 - off2_c;
    sens5  <= sensb4 - sens2_c;
    tout5  <= tout_c[18:0];
    d1_5   <= d1_4;
    // stage 6: sensitivity split at bit 21 so the floor shift needs no carry-in
    pa6    <= $signed({1'b0, d1_5}) * $signed(sens5[41:21]);
    pb6    <= d1_5 * sens5[20:0];
    off6   <= off5;
    tout6  <= tout5;
    // stage 7
    temp_centideg   <= tout6;
    press_centimbar <= psat_c;
  end

  // Every accepted pair yields one result
  a_latency_fwd: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##7 done)
    else $error("accepted pair produced no result");

  a_latency_back: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, 7))
    else $error("result without an accepted pair");

  // Below -15 C implies below 20 C
  a_frost_cold: assert property (@(posedge clk) disable iff (rst)
    (v3 && frost3) |-> cold3)
    else $error("frost correction outside cold range");

  // Temperature correction only exists in the cold range
  a_t2_cold: assert property (@(posedge clk) disable iff (rst)
    (v4 && !cold4) |=> (tout5 == $past(temp4)))
    else $error("second-order temperature term applied above 20 C");

endmodule

[tb/sv/baro_reading_checker.sv]
`timescale 1ns / 1ps

// Watches the sample, result and calibration channels of the barometer block,
// predicts each compensated reading and compares it with what comes out.
module baro_reading_checker
  import btpc_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic                   busy,
  input  logic [23:0]            raw_press,
  input  logic [23:0]            raw_temp,
  input  logic                   done,
  input  logic signed [18:0]     temp_centideg,
  input  logic signed [31:0]     press_centimbar,
  input  logic                   cfg_valid,
  input  logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [15:0]            cfg_data,
  output int unsigned            outstanding,
  output int                     fail_count
);

  typedef struct packed {
    logic signed [18:0] temp;
    logic signed [31:0] press;
  } reading_t;

  localparam longint PRESS_MAX = 64'sd2147483647;
  localparam longint PRESS_MIN = -64'sd2147483648;

  cal_t     cal = '0;
  reading_t expected_readings[$];
  int       mismatches = 0;

  assign fail_count = mismatches;

  // One line per mismatch
  task automatic report_mismatch(string what, longint got, longint want);
    $display("%0t ns: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    mismatches++;
  endtask

  // Second-order compensated temperature and pressure for one raw pair
  function automatic reading_t compensate(logic [23:0] d1_raw, logic [23:0] d2_raw);
    longint   d1, dt, temp, t2, off2, sens2, below, sq, cold, off, sens, p;
    longint   warm_ref, cold_ref;
    reading_t r;
    warm_ref = longint'(TEMP_REF);
    cold_ref = longint'(TEMP_REF) - longint'(COLD_SPAN);
    d1   = longint'(d1_raw);
    dt   = longint'(d2_raw) - longint'(cal.ref_temperature) * 256;
    temp = warm_ref + ((dt * longint'(cal.temp_sensitivity)) >>> 23);
    t2    = 0;
    off2  = 0;
    sens2 = 0;
    // cold side: second-order terms, plus the extra one in the very cold range
    if (temp < warm_ref) begin
      below = temp - warm_ref;
      sq    = 5 * below * below;
      t2    = (dt * dt) >>> 31;
      off2  = sq >>> 1;
      sens2 = sq >>> 2;
      if (temp < cold_ref) begin
        cold  = (temp - cold_ref) * (temp - cold_ref);
        off2  = off2 + 7 * cold;
        sens2 = sens2 + 11 * (cold >>> 1);
      end
    end
    off  = longint'(cal.offset_base) * 65536
           + ((longint'(cal.offset_temp_coeff) * dt) >>> 7) - off2;
    sens = longint'(cal.sens_base) * 32768
           + ((longint'(cal.sens_temp_coeff) * dt) >>> 8) - sens2;
    p = (((d1 * sens) >>> 21) - off) >>> 15;
    if (p > PRESS_MAX) p = PRESS_MAX;
    if (p < PRESS_MIN) p = PRESS_MIN;
    r.temp  = 19'(temp - t2);
    r.press = 32'(p);
    return r;
  endfunction

  // Channel monitor: results first, then new samples, then calibration writes
  always @(posedge clk) begin
    reading_t want;
    if (rst) begin
      cal = '0;
      expected_readings.delete();
    end else begin
      if (done) begin
        if (expected_readings.size() == 0) begin
          report_mismatch("unexpected reading", temp_centideg, 0);
        end else begin
          want = expected_readings.pop_front();
          if (temp_centideg !== want.temp)
            report_mismatch("temp_centideg", temp_centideg, want.temp);
          if (press_centimbar !== want.press)
            report_mismatch("press_centimbar", press_centimbar, want.press);
        end
      end
      if (start && !busy)
        expected_readings.push_back(compensate(raw_press, raw_temp));
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_SENS_BASE:         cal.sens_base         = cfg_data;
          REG_OFFSET_BASE:       cal.offset_base       = cfg_data;
          REG_SENS_TEMP_COEFF:   cal.sens_temp_coeff   = cfg_data;
          REG_OFFSET_TEMP_COEFF: cal.offset_temp_coeff = cfg_data;
          REG_REF_TEMPERATURE:   cal.ref_temperature   = cfg_data;
          REG_TEMP_SENSITIVITY:  cal.temp_sensitivity  = cfg_data;
          default: ;  // unmapped index, dropped by the block
        endcase
      end
    end
    outstanding <= expected_readings.size();
  end

endmodule

[tb/sv/tb_baro_temp_pressure_compensation.sv]
`timescale 1ns / 1ps

module tb_baro_temp_pressure_compensation
  import btpc_pkg::*;
();

  localparam int          PERIOD = 4;
  localparam int unsigned QUIET_LIMIT = 1000;
  localparam logic [23:0] MAX24 = 24'hFFFFFF;
  localparam logic [CFG_INDEX_W-1:0] REG_FIRST_UNMAPPED =
    CFG_INDEX_W'(REG_TEMP_SENSITIVITY) + CFG_INDEX_W'(1);

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   start = 1'b0;
  logic                   busy;
  logic [23:0]            raw_press = '0;
  logic [23:0]            raw_temp = '0;
  logic                   done;
  logic signed [18:0]     temp_centideg;
  logic signed [31:0]     press_centimbar;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [15:0]            cfg_data = '0;

  int unsigned outstanding;
  int          fail_count;
  int unsigned quiet = 0;
  logic [15:0] ref_word = '0;

  always #(PERIOD / 2) clk = ~clk;

  baro_temp_pressure_compensation u_dut (
    .clk             (clk),
    .rst             (rst),
    .start           (start),
    .busy            (busy),
    .raw_press       (raw_press),
    .raw_temp        (raw_temp),
    .done            (done),
    .temp_centideg   (temp_centideg),
    .press_centimbar (press_centimbar),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  baro_reading_checker u_checker (
    .clk             (clk),
    .rst             (rst),
    .start           (start),
    .busy            (busy),
    .raw_press       (raw_press),
    .raw_temp        (raw_temp),
    .done            (done),
    .temp_centideg   (temp_centideg),
    .press_centimbar (press_centimbar),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .outstanding     (outstanding),
    .fail_count      (fail_count)
  );

  // Watchdog: ends the run after too long without any transaction
  always @(posedge clk) begin
    if (rst || (start && !busy) || done || (cfg_valid && cfg_ready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet == QUIET_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  // Valid is left high so back-to-back writes follow one another without a gap
  task automatic write_cal(logic [CFG_INDEX_W-1:0] index, logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Full calibration set, plus a write to an unmapped index that must be dropped
  task automatic load_cal(logic [15:0] c1, logic [15:0] c2, logic [15:0] c3,
                          logic [15:0] c4, logic [15:0] c5, logic [15:0] c6);
    write_cal(REG_SENS_BASE, c1);
    write_cal(REG_OFFSET_BASE, c2);
    write_cal(REG_SENS_TEMP_COEFF, c3);
    write_cal(REG_OFFSET_TEMP_COEFF, c4);
    write_cal(REG_REF_TEMPERATURE, c5);
    write_cal(REG_TEMP_SENSITIVITY, c6);
    write_cal(REG_FIRST_UNMAPPED + CFG_INDEX_W'($urandom_range(0, 1)), 16'($urandom));
    cfg_valid <= 1'b0;
    ref_word = c5;
  endtask

  // Start stays high between consecutive samples of a burst
  task automatic send_pair(logic [23:0] press, logic [23:0] temp);
    start     <= 1'b1;
    raw_press <= press;
    raw_temp  <= temp;
    do @(posedge clk); while (busy);
  endtask

  // Gap in the sample stream, with junk on the data lines
  task automatic pause(int unsigned cycles);
    start     <= 1'b0;
    raw_press <= 24'($urandom);
    raw_temp  <= 24'($urandom);
    repeat (cycles) @(posedge clk);
  endtask

  task automatic drain_results();
    start <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  function automatic logic [15:0] pick_cal_word();
    case ($urandom_range(0, 5))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [23:0] pick_raw_press();
    case ($urandom_range(0, 7))
      0:       return 24'h000000;
      1:       return MAX24;
      default: return 24'($urandom);
    endcase
  endfunction

  // Mostly near the reference reading so all three temperature ranges get hit
  function automatic logic [23:0] pick_raw_temp();
    longint v;
    if ($urandom_range(0, 3) == 0) return 24'($urandom);
    v = longint'(ref_word) * 256 + longint'($urandom_range(0, 1 << 22)) - (1 << 21);
    if (v < 0) v = 0;
    if (v > longint'(MAX24)) v = longint'(MAX24);
    return 24'(v);
  endfunction

  // Random samples in bursts, with gaps and the odd full drain
  task automatic run_traffic(int unsigned count);
    int unsigned sent, burst;
    sent = 0;
    while (sent < count) begin
      burst = $urandom_range(1, 24);
      while (burst > 0 && sent < count) begin
        send_pair(pick_raw_press(), pick_raw_temp());
        sent++;
        burst--;
      end
      if ($urandom_range(0, 15) == 0)
        drain_results();
      else if ($urandom_range(0, 3) != 0)
        pause($urandom_range(1, 8));
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // calibration still at its reset value
    send_pair(MAX24, MAX24);
    send_pair(24'h000000, 24'h000000);
    drain_results();

    // full-scale calibration
    load_cal(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_pair(24'h000000, 24'h000000);
    send_pair(MAX24, MAX24);
    send_pair(MAX24, 24'h000000);
    drain_results();

    // mid-scale reference: raw_temp steps one count across 20.00 C and -15.00 C
    load_cal(16'd40000, 16'd36000, 16'd23000, 16'd23000, 16'h8000, 16'h8000);
    send_pair(24'h000000, 24'h800000);
    send_pair(MAX24, 24'h7FFFFF);
    send_pair(24'h800000, 24'd7492608);
    send_pair(24'h800000, 24'd7492607);
    send_pair(MAX24, MAX24);
    send_pair(24'h000000, 24'h000000);
    send_pair(MAX24, 24'h000000);
    send_pair(24'h000000, MAX24);
    send_pair(24'h555555, 24'hAAAAAA);
    send_pair(24'hAAAAAA, 24'h555555);
    drain_results();

    // all words written to zero
    load_cal(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_pair(MAX24, 24'h000000);
    send_pair(24'h000000, MAX24);
    drain_results();

    // random calibration sets
    repeat (5) begin
      load_cal(pick_cal_word(), pick_cal_word(), pick_cal_word(),
               pick_cal_word(), pick_cal_word(), pick_cal_word());
      run_traffic(100);
      drain_results();
    end

    repeat (16) @(posedge clk);
    if (fail_count == 0 && outstanding == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
